@@ sv/assert_macros.svh @@
// assertion macros for the ready queue scheduler checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define RQS_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define RQS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/rqs_pkg.sv @@
// package with sizes, codes and types of the ready queue scheduler
package rqs_pkg;

  localparam int DEPTH     = 16;
  localparam int ID_BITS   = 8;
  localparam int PRIO_BITS = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_NEXT   = 2'd2;

  localparam logic [1:0] MODE_SIMPLE   = 2'd0;
  localparam logic [1:0] MODE_CIRCULAR = 2'd1;
  localparam logic [1:0] MODE_PRIORITY = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOTHING   = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RM_SCAN,
    ST_RM_SHIFT,
    ST_RESCAN,
    ST_NX_DATA,
    ST_DONE
  } state_t;

endpackage

@@ sv/ready_queue_scheduler_core.sv @@
// Ready queue scheduler: holds up to DEPTH (process id, priority) entries in
// insertion order in one RAM with a registered read port, walked by a small
// sequencer that reads one entry per cycle. A remove scans for the id, shifts
// the tail down one slot per cycle and, when the best entry was removed,
// rescans priorities. The single RAM read port is why entries are walked one
// at a time. A result waits in an output register, so the next word is taken
// while it is still pending.
module ready_queue_scheduler_core
  import rqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // proc_id[7:0], priority_req[23:8]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // chosen_id[7:0], entries[12:8], zero[15:13]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data        // mode[1:0]
);

  state_t state, state_next;

  logic [1:0]           mode;
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     cur, cur_next;
  logic [IDX_W-1:0]     best, best_next;
  logic [PRIO_BITS-1:0] best_prio, best_prio_next;
  logic [1:0]           op_r;
  logic [ID_BITS-1:0]   id_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic [CNT_W-1:0]     scan, scan_next;
  logic                 lag_valid, lag_valid_next;
  logic [IDX_W-1:0]     lag_idx, lag_idx_next;
  logic [IDX_W-1:0]     rm_idx, rm_idx_next;
  logic [1:0]           res_status, res_status_next;
  logic [ID_BITS-1:0]   res_chosen, res_chosen_next;
  logic                 out_valid, out_valid_next;
  logic [1:0]           out_status;
  logic [ID_BITS-1:0]   out_chosen;
  logic [CNT_W-1:0]     out_entries;
  logic                 out_load;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  entry_t               ram_rdata;
  logic [$bits(entry_t)-1:0] ram_rdata_raw;

  logic [CNT_W-1:0]     count_dec;
  logic [CNT_W-1:0]     cur_inc;
  logic                 accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {3'b000, out_entries, out_chosen};
  assign ram_rdata     = entry_t'(ram_rdata_raw);
  assign count_dec     = count - CNT_W'(1);
  assign cur_inc       = {1'b0, cur} + CNT_W'(1);

  rqs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_SIMPLE;
      count     <= '0;
      cur       <= '0;
      best      <= '0;
      lag_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cur       <= cur_next;
      best      <= best_next;
      lag_valid <= lag_valid_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_prio  <= best_prio_next;
    scan       <= scan_next;
    lag_idx    <= lag_idx_next;
    rm_idx     <= rm_idx_next;
    res_status <= res_status_next;
    res_chosen <= res_chosen_next;
    if (accept) begin
      op_r   <= s_axis_tuser;
      id_r   <= s_axis_tdata[ID_BITS-1:0];
      prio_r <= s_axis_tdata[ID_BITS +: PRIO_BITS];
    end
    if (out_load) begin
      out_status  <= res_status;
      out_chosen  <= res_chosen;
      out_entries <= count;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    cur_next        = cur;
    best_next       = best;
    best_prio_next  = best_prio;
    scan_next       = scan;
    lag_valid_next  = 1'b0;
    lag_idx_next    = lag_idx;
    rm_idx_next     = rm_idx;
    res_status_next = res_status;
    res_chosen_next = res_chosen;
    out_valid_next  = out_valid && !m_axis_tready;
    out_load        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = lag_idx - IDX_W'(1);
    ram_wdata       = ram_rdata;
    ram_raddr       = scan[IDX_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_status_next = STAT_OK;
          res_chosen_next = '0;
          state_next      = ST_EXEC;
        end
      end

      ST_EXEC: begin
        scan_next  = '0;
        state_next = ST_DONE;
        case (op_r)
          OP_INSERT: begin
            if (count == CNT_W'(DEPTH)) begin
              res_status_next = STAT_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = count[IDX_W-1:0];
              ram_wdata.id   = id_r;
              ram_wdata.prio = prio_r;
              if (count == '0) begin
                cur_next       = '0;
                best_next      = '0;
                best_prio_next = prio_r;
              end else if (prio_r < best_prio) begin
                best_next      = count[IDX_W-1:0];
                best_prio_next = prio_r;
              end
              count_next = count + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            state_next = ST_RM_SCAN;
          end
          OP_NEXT: begin
            if (count == '0 || mode == MODE_NONE) begin
              res_status_next = STAT_NOTHING;
            end else begin
              ram_raddr  = (mode == MODE_PRIORITY) ? best : cur;
              state_next = ST_NX_DATA;
            end
          end
          default: begin
            res_status_next = STAT_OK;
          end
        endcase
      end

      ST_RM_SCAN: begin
        if (lag_valid && ram_rdata.id == id_r) begin
          rm_idx_next = lag_idx;
          scan_next   = {1'b0, lag_idx} + CNT_W'(1);
          state_next  = ST_RM_SHIFT;
        end else if (scan < count) begin
          lag_valid_next = 1'b1;
          lag_idx_next   = scan[IDX_W-1:0];
          scan_next      = scan + CNT_W'(1);
        end else begin
          res_status_next = STAT_NOT_FOUND;
          state_next      = ST_DONE;
        end
      end

      ST_RM_SHIFT: begin
        ram_we = lag_valid;
        if (scan < count) begin
          lag_valid_next = 1'b1;
          lag_idx_next   = scan[IDX_W-1:0];
          scan_next      = scan + CNT_W'(1);
        end else if (!lag_valid) begin
          count_next = count_dec;
          state_next = ST_DONE;
          if (count_dec == '0) begin
            cur_next  = '0;
            best_next = '0;
          end else begin
            if (rm_idx == cur) begin
              if ({1'b0, cur} >= count_dec) begin
                cur_next = '0;
              end
            end else if (rm_idx < cur) begin
              cur_next = cur - IDX_W'(1);
            end
            if (rm_idx == best) begin
              scan_next  = '0;
              state_next = ST_RESCAN;
            end else if (rm_idx < best) begin
              best_next = best - IDX_W'(1);
            end
          end
        end
      end

      ST_RESCAN: begin
        if (lag_valid && (lag_idx == '0 || ram_rdata.prio < best_prio)) begin
          best_next      = lag_idx;
          best_prio_next = ram_rdata.prio;
        end
        if (scan < count) begin
          lag_valid_next = 1'b1;
          lag_idx_next   = scan[IDX_W-1:0];
          scan_next      = scan + CNT_W'(1);
        end else if (!lag_valid) begin
          state_next = ST_DONE;
        end
      end

      ST_NX_DATA: begin
        res_chosen_next = ram_rdata.id;
        if (mode == MODE_CIRCULAR) begin
          cur_next = (cur_inc >= count) ? '0 : cur_inc[IDX_W-1:0];
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/rqs_ram.sv @@
// generic single write port ram with registered read
module rqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rqs_checker.sv @@
// port-level checks of the ready queue scheduler, bound to the top level
`include "assert_macros.svh"

module rqs_checker
  import rqs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `RQS_ASSERT_NOW(a_full_at_depth, m_axis_tvalid && m_axis_tuser == STAT_FULL, m_axis_tdata[12:8] == 5'(DEPTH), "full status with table not full")
  `RQS_ASSERT_NOW(a_entries_range, m_axis_tvalid, m_axis_tdata[12:8] <= 5'(DEPTH), "entry count above depth")
  `RQS_ASSERT_NOW(a_chosen_zero, m_axis_tvalid && m_axis_tuser != STAT_OK, m_axis_tdata[7:0] == '0, "chosen id set on a failed word")
  `RQS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready while a word is in work")
  `RQS_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result dropped while stalled")

endmodule

bind ready_queue_scheduler_core rqs_checker u_rqs_checker (.*);

@@ tb/ready_queue_checker.sv @@
// checker that predicts and compares every result word of the ready queue scheduler
module ready_queue_checker
  import rqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // proc_id[7:0], priority_req[23:8]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // chosen_id[7:0], entries[12:8], zero[15:13]
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_data,       // mode[1:0]
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_BITS-1:0] chosen;
    logic [CNT_W-1:0]   entries;
  } sched_result_t;

  logic [ID_BITS-1:0]   ready_ids   [DEPTH];
  logic [PRIO_BITS-1:0] ready_prios [DEPTH];
  int                   held;
  int                   cur_slot;
  int                   best_slot;
  logic [1:0]           sched_mode;
  sched_result_t        sched_results_q [$];
  sched_result_t        want;
  sched_result_t        got;
  sched_result_t        res;
  int                   bad_words;

  task automatic schedule_word(input logic [1:0] op, input logic [ID_BITS-1:0] id,
                               input logic [PRIO_BITS-1:0] prio,
                               output sched_result_t r);
    int hit;
    int k;
    r.status = STAT_OK;
    r.chosen = '0;
    case (op)
      OP_INSERT: begin
        if (held >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          ready_ids[held]   = id;
          ready_prios[held] = prio;
          if (held == 0) begin
            cur_slot  = 0;
            best_slot = 0;
          end else if (prio < ready_prios[best_slot]) begin
            best_slot = held;
          end
          held++;
        end
      end
      OP_REMOVE: begin
        hit = held;
        for (k = 0; k < held && hit == held; k++)
          if (ready_ids[k] == id) hit = k;
        if (hit >= held) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          for (k = hit; k + 1 < held; k++) begin
            ready_ids[k]   = ready_ids[k+1];
            ready_prios[k] = ready_prios[k+1];
          end
          held--;
          if (held == 0) begin
            cur_slot  = 0;
            best_slot = 0;
          end else begin
            if (hit == cur_slot) begin
              if (cur_slot >= held) cur_slot = 0;
            end else if (hit < cur_slot) begin
              cur_slot--;
            end
            if (hit == best_slot) begin
              // full priority rescan, earliest wins ties
              best_slot = 0;
              for (k = 1; k < held; k++)
                if (ready_prios[k] < ready_prios[best_slot]) best_slot = k;
            end else if (hit < best_slot) begin
              best_slot--;
            end
          end
        end
      end
      OP_NEXT: begin
        if (held == 0 || sched_mode == MODE_NONE) begin
          r.status = STAT_NOTHING;
        end else if (sched_mode == MODE_PRIORITY) begin
          r.chosen = ready_ids[best_slot];
        end else begin
          r.chosen = ready_ids[cur_slot];
          if (sched_mode == MODE_CIRCULAR) begin
            cur_slot++;
            if (cur_slot >= held) cur_slot = 0;
          end
        end
      end
      default: ;
    endcase
    r.entries = held[CNT_W-1:0];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held       = 0;
      cur_slot   = 0;
      best_slot  = 0;
      sched_mode = MODE_SIMPLE;
      bad_words  = 0;
      sched_results_q.delete();
      outstanding <= 0;
      errors      <= 0;
    end else begin
      if (cfg_valid && cfg_ready) sched_mode = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tuser;
        got.chosen  = m_axis_tdata[7:0];
        got.entries = m_axis_tdata[12:8];
        if (sched_results_q.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("rqs check: unexpected word status %0d id %0d entries %0d",
                     got.status, got.chosen, got.entries);
        end else begin
          want = sched_results_q.pop_front();
          if (got.status !== want.status || got.chosen !== want.chosen ||
              got.entries !== want.entries) begin
            bad_words++;
            if (bad_words <= 10)
              $display("rqs check: expected status %0d id %0d entries %0d, got %0d %0d %0d",
                       want.status, want.chosen, want.entries,
                       got.status, got.chosen, got.entries);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        schedule_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8], res);
        sched_results_q.push_back(res);
      end
      outstanding <= sched_results_q.size();
      errors      <= bad_words;
    end
  end

endmodule

@@ tb/tb.sv @@
// top of the ready queue scheduler testbench: clock, reset, stimulus and verdict
module tb
  import rqs_pkg::*;
();

  localparam int DRAIN_CYCLES = 3 * DEPTH + 6;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // proc_id[7:0], priority_req[23:8]
  logic [1:0]  s_axis_tuser;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // chosen_id[7:0], entries[12:8], zero[15:13]
  logic [1:0]  m_axis_tuser;   // status[1:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;       // mode[1:0]
  int          errors;
  int          outstanding;

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_left;

  ready_queue_scheduler_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  ready_queue_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("ready_queue_scheduler_core: mismatch");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic put_word(input logic [1:0] op, input logic [ID_BITS-1:0] id,
                          input logic [PRIO_BITS-1:0] prio);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {prio, id};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain();
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] m, input int tx_pct, input int rx_pct,
                           input int count, input bit long_hold);
    int n;
    int pick;
    int fill_bias;
    logic [1:0]           op;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    write_mode(m);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    fill_bias    = 0;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) fill_bias = $urandom_range(2) * 15;
      if (long_hold && n == 20) hold_left = 300;
      pick = $urandom_range(99);
      if (pick < 35 + fill_bias)      op = OP_INSERT;
      else if (pick < 65)             op = OP_REMOVE;
      else if (pick < 95)             op = OP_NEXT;
      else                            op = 2'd3;
      if ($urandom_range(3) == 0) id = ID_BITS'($urandom);
      else                        id = ID_BITS'($urandom_range(15));
      case ($urandom_range(3))
        0: prio = PRIO_BITS'($urandom_range(7));
        1: prio = PRIO_BITS'($urandom);
        2: prio = $urandom_range(1) ? {PRIO_BITS{1'b1}} : '0;
        default: prio = PRIO_BITS'($urandom_range(255));
      endcase
      put_word(op, id, prio);
    end
  endtask

  initial begin
    int k;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    cfg_valid     = 1'b0;
    cfg_data      = MODE_SIMPLE;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_left     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, ties, unknown op, simple mode
    put_word(OP_NEXT,   8'h00, 16'h0000);
    put_word(OP_REMOVE, 8'h07, 16'h0000);
    put_word(OP_INSERT, 8'h00, 16'hffff);
    put_word(OP_INSERT, 8'hff, 16'h0000);
    put_word(OP_INSERT, 8'h55, 16'h0000);
    put_word(OP_INSERT, 8'haa, 16'h8000);
    put_word(2'd3,      8'hff, 16'hffff);
    put_word(OP_NEXT,   8'h00, 16'h0000);
    put_word(OP_NEXT,   8'h00, 16'h0000);
    put_word(OP_REMOVE, 8'h99, 16'h0000);

    // circular: advance to the tail, remove it so current wraps
    write_mode(MODE_CIRCULAR);
    repeat (3) put_word(OP_NEXT, 8'h00, 16'h0000);
    put_word(OP_REMOVE, 8'haa, 16'h0000);
    put_word(OP_NEXT,   8'h00, 16'h0000);

    // priority: remove best, remove below best, then fill past full
    write_mode(MODE_PRIORITY);
    put_word(OP_NEXT,   8'h00, 16'h0000);
    put_word(OP_REMOVE, 8'hff, 16'h0000);
    put_word(OP_NEXT,   8'h00, 16'h0000);
    put_word(OP_REMOVE, 8'h00, 16'h0000);
    put_word(OP_NEXT,   8'h00, 16'h0000);
    for (k = 0; k < 17; k++)
      put_word(OP_INSERT, 8'(k % 8), 16'(k * 4099));
    put_word(OP_REMOVE, 8'h03, 16'h0000);
    put_word(OP_NEXT,   8'h00, 16'h0000);

    write_mode(MODE_NONE);
    put_word(OP_NEXT, 8'h00, 16'h0000);

    // random phases
    run_phase(MODE_CIRCULAR, 0, 0, 130, 1'b1);
    run_phase(MODE_PRIORITY, 74, 0, 120, 1'b0);
    run_phase(MODE_SIMPLE, 0, 74, 120, 1'b0);
    for (k = 0; k < 5; k++)
      run_phase(2'($urandom_range(3)), 9, 9, 30, 1'b0);

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("ready_queue_scheduler_core: match");
    end else begin
      $display("ready_queue_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule
